/* rtl/ltns_pkg.sv */
// Shared widths, constants and codes for the lumped thermal node stepper.
package ltns_pkg;

  // field widths
  localparam int TEMP_W  = 20;
  localparam int POW_W   = 18;
  localparam int DT_W    = 20;
  localparam int SCALE_W = 17;
  localparam int FRAC_W  = 15;
  localparam int CAP_W   = 24;
  localparam int COND_W  = 24;
  localparam int BIAS_W  = 16;
  localparam int OUT_P_W = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 24;

  // internal widths
  localparam int Q16_SHIFT  = 16;
  localparam int DT_SHIFT   = 12;
  localparam int LOSS_MAG_W = 28;  // cond * |diff| >> 16
  localparam int NET_MAG_W  = 29;  // |heater + solar - loss|
  localparam int TGT_W      = TEMP_W + 1;
  localparam int CMP_W      = TGT_W + FRAC_W;

  // bit-serial multiplier
  localparam int MUL_A_W   = NET_MAG_W;
  localparam int MUL_B_W   = 20;
  localparam int MUL_P_W   = MUL_A_W + 1 + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  // restoring divider
  localparam int DIV_N_W   = MUL_A_W + DT_W - DT_SHIFT;
  localparam int DIV_D_W   = CAP_W;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // constants
  localparam logic [TEMP_W-1:0]  TEMP_MAX       = '1;
  localparam logic [TEMP_W-1:0]  TEMP_RESET     = 20'd76800;
  localparam logic [SCALE_W-1:0] ONE_Q16        = 17'd65536;
  localparam logic [FRAC_W-1:0]  ONE_Q14        = 15'd16384;
  localparam logic [CAP_W-1:0]   FALLBACK_CAP   = 24'd12800;
  localparam logic [COND_W-1:0]  FALLBACK_COND  = 24'd52429;
  localparam logic [TEMP_W-1:0]  BIAS_THRESHOLD = 20'd102400;
  localparam logic [TGT_W-1:0]   IDLE_LIMIT     = 21'd79360;

  // register reset values
  localparam logic [TEMP_W-1:0] NIGHT_RESET  = 20'd64000;
  localparam logic [TEMP_W-1:0] DAY_RESET    = 20'd76800;
  localparam logic [CAP_W-1:0]  CAP_RESET    = 24'd12800;
  localparam logic [COND_W-1:0] COND_RESET   = 24'd52429;
  localparam logic [POW_W-1:0]  PEAK_RESET   = 18'd0;
  localparam logic [TEMP_W-1:0] TARGET_RESET = 20'd76800;
  localparam logic [BIAS_W-1:0] BIAS_RESET   = 16'd0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NIGHT_AMBIENT  = 3'd0,
    CFG_DAY_AMBIENT    = 3'd1,
    CFG_HEAT_CAPACITY  = 3'd2,
    CFG_LOSS_COND      = 3'd3,
    CFG_SOLAR_PEAK     = 3'd4,
    CFG_TARGET_RAW     = 3'd5,
    CFG_TARGET_BIAS    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BAND_IDLE   = 2'd0,
    BAND_BELOW  = 2'd1,
    BAND_WITHIN = 2'd2,
    BAND_ABOVE  = 2'd3
  } band_e;

endpackage

/* rtl/ltns_mul.sv */
// Bit-serial dual shift-add multiplier: a*b + c*d, one multiplier bit per cycle.
module ltns_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [ltns_pkg::MUL_CNT_W-1:0] len_i,
  input  logic [ltns_pkg::MUL_A_W-1:0]   a_i,
  input  logic [ltns_pkg::MUL_B_W-1:0]   b_i,
  input  logic [ltns_pkg::MUL_A_W-1:0]   c_i,
  input  logic [ltns_pkg::MUL_B_W-1:0]   d_i,
  output logic                           done_o,
  output logic [ltns_pkg::MUL_P_W-1:0]   prod_o
);
  import ltns_pkg::*;

  logic                 run_q, done_q;
  logic [MUL_CNT_W-1:0] cnt_q;
  logic [MUL_A_W-1:0]   a_q, c_q;
  logic [MUL_B_W-1:0]   b_q, d_q;
  logic [MUL_A_W:0]     h_q;
  logic [MUL_B_W-1:0]   l_q;
  logic [MUL_A_W:0]     addend;
  logic [MUL_A_W+1:0]   sum;

  assign addend = (b_q[0] ? {1'b0, a_q} : '0) + (d_q[0] ? {1'b0, c_q} : '0);
  assign sum    = {1'b0, h_q} + {1'b0, addend};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= len_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - MUL_CNT_W'(1);
        if (cnt_q == MUL_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial product shifts right; low bits fall into l_q
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      c_q <= c_i;
      d_q <= d_i;
      h_q <= '0;
      l_q <= '0;
    end else if (run_q) begin
      b_q <= b_q >> 1;
      d_q <= d_q >> 1;
      h_q <= sum[MUL_A_W+1:1];
      l_q <= {sum[0], l_q[MUL_B_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {h_q, l_q};

endmodule

/* rtl/ltns_div.sv */
// Restoring divider, one quotient bit per cycle.
module ltns_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ltns_pkg::DIV_N_W-1:0] num_i,
  input  logic [ltns_pkg::DIV_D_W-1:0] den_i,
  output logic                         done_o,
  output logic [ltns_pkg::DIV_N_W-1:0] quo_o
);
  import ltns_pkg::*;

  logic                 run_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N_W-1:0]   quo_q;
  logic [DIV_D_W-1:0]   rem_q, den_q;
  logic [DIV_D_W:0]     shifted;
  logic [DIV_D_W+1:0]   trial;
  logic                 ge;

  assign shifted = {rem_q, quo_q[DIV_N_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign ge      = !trial[DIV_D_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_N_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits enter at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DIV_N_W-2:0], ge};
      rem_q <= ge ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/lumped_thermal_node_stepper.sv */
// Lumped thermal node stepper: one forward-Euler tick per input beat.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+--------------------------------------
//   in      | sink      | in_valid_i/in_stall_o | heater, time step, scale, fractions
//   out     | source    | out_valid_o/out_stall_i | temp, ambient, loss, net, band
//   cfg     | sink      | cfg_we_i              | cfg_addr_i, cfg_wdata_i
//
// Beats are worked one at a time; a beat's result appears in the same cycle
// that the input is freed for the next beat. The time is set by seven runs of
// the one-bit-per-cycle multiplier and the 37-step divider.
// Reset restores the register defaults and the node temperature (300 K).
// A waiting result holds the output; the next beat is accepted meanwhile and
// its final step holds until the output register is free.
module lumped_thermal_node_stepper (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ltns_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [ltns_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ltns_pkg::POW_W-1:0]         heater_power_i,
  input  logic [ltns_pkg::DT_W-1:0]          time_step_i,
  input  logic [ltns_pkg::SCALE_W-1:0]       solar_scale_i,
  input  logic [ltns_pkg::FRAC_W-1:0]        lower_fraction_i,
  input  logic [ltns_pkg::FRAC_W-1:0]        upper_fraction_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ltns_pkg::TEMP_W-1:0]        node_temp_o,
  output logic [ltns_pkg::TEMP_W-1:0]        ambient_temp_o,
  output logic signed [ltns_pkg::OUT_P_W-1:0] loss_power_o,
  output logic signed [ltns_pkg::OUT_P_W-1:0] net_power_o,
  output logic [1:0]                         band_class_o
);
  import ltns_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AMB  = 4'd1;
  localparam logic [3:0] ST_SOL  = 4'd2;
  localparam logic [3:0] ST_LOSS = 4'd3;
  localparam logic [3:0] ST_MAG  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_TGT  = 4'd6;
  localparam logic [3:0] ST_LO   = 4'd7;
  localparam logic [3:0] ST_HI   = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  // configuration and node state
  logic [TEMP_W-1:0] night_q, day_q, traw_q, temp_q;
  logic [CAP_W-1:0]  cap_q;
  logic [COND_W-1:0] cond_q;
  logic [POW_W-1:0]  peak_q;
  logic [BIAS_W-1:0] tbias_q;

  logic [3:0] state_q, state_d;
  logic       launch_q, launch_d;
  logic       out_valid_q;
  logic       in_acc, out_load;

  // per-beat working registers
  logic [POW_W-1:0]          heater_q, solar_q;
  logic [DT_W-1:0]           dt_q;
  logic [SCALE_W-1:0]        scale_q;
  logic [FRAC_W-1:0]         lo_q, hi_q;
  logic [TEMP_W-1:0]         amb_q;
  logic signed [OUT_P_W-1:0] loss_q, net_q;
  logic [TGT_W-1:0]          tgt_q;
  logic [CMP_W-1:0]          lo_prod_q;
  logic [1:0]                band_q;

  // output register
  logic [TEMP_W-1:0]         o_temp_q, o_amb_q;
  logic signed [OUT_P_W-1:0] o_loss_q, o_net_q;
  logic [1:0]                o_band_q;

  // input conditioning
  logic [SCALE_W-1:0] scale_cl;
  logic [FRAC_W-1:0]  lo_cl, hi_cl;

  // multiplier and divider hookup
  logic                 mul_start, mul_done, div_start, div_done;
  logic [MUL_CNT_W-1:0] mul_len;
  logic [MUL_A_W-1:0]   mul_a, mul_c;
  logic [MUL_B_W-1:0]   mul_b, mul_d;
  logic [MUL_P_W-1:0]   mp;
  logic [DIV_N_W-1:0]   div_quo;

  logic [CAP_W-1:0]          cap_eff;
  logic [COND_W-1:0]         cond_eff;
  logic                      diff_neg;
  logic [TEMP_W-1:0]         abs_diff;
  logic signed [OUT_P_W-1:0] loss_v, net_v, net_neg_v;
  logic [NET_MAG_W-1:0]      net_abs;
  logic                      quo_big;
  logic [TEMP_W:0]           temp_sum;
  logic [TEMP_W-1:0]         temp_new;
  logic [TGT_W-1:0]          tgt_v;
  logic [CMP_W-1:0]          tq, hi_prod;
  logic [1:0]                band_v;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  assign scale_cl = (solar_scale_i > ONE_Q16) ? ONE_Q16 : solar_scale_i;
  assign lo_cl    = (lower_fraction_i > ONE_Q14) ? ONE_Q14 : lower_fraction_i;
  assign hi_cl    = (upper_fraction_i < lo_cl) ? lo_cl : upper_fraction_i;

  assign cap_eff  = (cap_q == '0) ? FALLBACK_CAP : cap_q;
  assign cond_eff = (cond_q == '0) ? FALLBACK_COND : cond_q;

  assign diff_neg = temp_q < amb_q;
  assign abs_diff = diff_neg ? (amb_q - temp_q) : (temp_q - amb_q);

  assign loss_v = diff_neg ? -OUT_P_W'(signed'({1'b0, mp[MUL_B_W-TEMP_W+Q16_SHIFT +: LOSS_MAG_W]}))
                           :  OUT_P_W'(signed'({1'b0, mp[MUL_B_W-TEMP_W+Q16_SHIFT +: LOSS_MAG_W]}));
  assign net_v  = OUT_P_W'(signed'({1'b0, heater_q})) + OUT_P_W'(signed'({1'b0, solar_q}))
                  - loss_v;

  assign net_neg_v = -net_q;
  assign net_abs   = net_q[OUT_P_W-1] ? net_neg_v[NET_MAG_W-1:0] : net_q[NET_MAG_W-1:0];

  // saturating temperature update from the quotient
  assign quo_big  = |div_quo[DIV_N_W-1:TEMP_W];
  assign temp_sum = {1'b0, temp_q} + {1'b0, div_quo[TEMP_W-1:0]};
  always_comb begin
    if (net_q[OUT_P_W-1]) begin
      temp_new = (quo_big || (div_quo[TEMP_W-1:0] > temp_q)) ? '0
                 : temp_q - div_quo[TEMP_W-1:0];
    end else begin
      temp_new = (quo_big || temp_sum[TEMP_W]) ? TEMP_MAX : temp_sum[TEMP_W-1:0];
    end
  end

  assign tgt_v = (traw_q > BIAS_THRESHOLD)
                 ? {1'b0, traw_q} + {1'b0, mp[MUL_B_W-BIAS_W+Q16_SHIFT +: TEMP_W]}
                 : {1'b0, traw_q};

  assign tq      = CMP_W'({temp_q, (FRAC_W-1)'(0)});
  assign hi_prod = mp[MUL_B_W-FRAC_W +: CMP_W];

  always_comb begin
    if (tgt_q <= IDLE_LIMIT) begin
      band_v = BAND_IDLE;
    end else if (tq < lo_prod_q) begin
      band_v = BAND_BELOW;
    end else if (tq > hi_prod) begin
      band_v = BAND_ABOVE;
    end else begin
      band_v = BAND_WITHIN;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_c   = '0;
    mul_d   = '0;
    mul_len = '0;
    unique case (state_q)
      ST_AMB: begin
        mul_a   = MUL_A_W'(night_q);
        mul_b   = MUL_B_W'(ONE_Q16 - scale_q);
        mul_c   = MUL_A_W'(day_q);
        mul_d   = MUL_B_W'(scale_q);
        mul_len = MUL_CNT_W'(SCALE_W);
      end
      ST_SOL: begin
        mul_a   = MUL_A_W'(peak_q);
        mul_b   = MUL_B_W'(scale_q);
        mul_len = MUL_CNT_W'(SCALE_W);
      end
      ST_LOSS: begin
        mul_a   = MUL_A_W'(cond_eff);
        mul_b   = MUL_B_W'(abs_diff);
        mul_len = MUL_CNT_W'(TEMP_W);
      end
      ST_MAG: begin
        mul_a   = net_abs;
        mul_b   = MUL_B_W'(dt_q);
        mul_len = MUL_CNT_W'(DT_W);
      end
      ST_TGT: begin
        mul_a   = MUL_A_W'(traw_q);
        mul_b   = MUL_B_W'(tbias_q);
        mul_len = MUL_CNT_W'(BIAS_W);
      end
      ST_LO: begin
        mul_a   = MUL_A_W'(tgt_q);
        mul_b   = MUL_B_W'(lo_q);
        mul_len = MUL_CNT_W'(FRAC_W);
      end
      ST_HI: begin
        mul_a   = MUL_A_W'(tgt_q);
        mul_b   = MUL_B_W'(hi_q);
        mul_len = MUL_CNT_W'(FRAC_W);
      end
      default: begin
      end
    endcase
  end

  assign mul_start = launch_q && (state_q != ST_DIV);
  assign div_start = launch_q && (state_q == ST_DIV);

  ltns_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .len_i   (mul_len),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .c_i     (mul_c),
    .d_i     (mul_d),
    .done_o  (mul_done),
    .prod_o  (mp)
  );

  ltns_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mp[MUL_B_W-DT_W+DT_SHIFT +: DIV_N_W]),
    .den_i   (cap_eff),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    launch_d = 1'b0;
    unique case (state_q)
      ST_IDLE: if (in_acc) begin
        state_d  = ST_AMB;
        launch_d = 1'b1;
      end
      ST_AMB:  if (mul_done) begin
        state_d  = ST_SOL;
        launch_d = 1'b1;
      end
      ST_SOL:  if (mul_done) begin
        state_d  = ST_LOSS;
        launch_d = 1'b1;
      end
      ST_LOSS: if (mul_done) begin
        state_d  = ST_MAG;
        launch_d = 1'b1;
      end
      ST_MAG:  if (mul_done) begin
        state_d  = ST_DIV;
        launch_d = 1'b1;
      end
      ST_DIV:  if (div_done) begin
        state_d  = ST_TGT;
        launch_d = 1'b1;
      end
      ST_TGT:  if (mul_done) begin
        state_d  = ST_LO;
        launch_d = 1'b1;
      end
      ST_LO:   if (mul_done) begin
        state_d  = ST_HI;
        launch_d = 1'b1;
      end
      ST_HI:   if (mul_done) begin
        state_d  = ST_OUT;
      end
      ST_OUT:  if (out_load) begin
        state_d  = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      temp_q      <= TEMP_RESET;
      night_q     <= NIGHT_RESET;
      day_q       <= DAY_RESET;
      cap_q       <= CAP_RESET;
      cond_q      <= COND_RESET;
      peak_q      <= PEAK_RESET;
      traw_q      <= TARGET_RESET;
      tbias_q     <= BIAS_RESET;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_DIV) && div_done) begin
        temp_q <= temp_new;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_addr_i))
          CFG_NIGHT_AMBIENT: night_q <= cfg_wdata_i[TEMP_W-1:0];
          CFG_DAY_AMBIENT:   day_q   <= cfg_wdata_i[TEMP_W-1:0];
          CFG_HEAT_CAPACITY: cap_q   <= cfg_wdata_i[CAP_W-1:0];
          CFG_LOSS_COND:     cond_q  <= cfg_wdata_i[COND_W-1:0];
          CFG_SOLAR_PEAK:    peak_q  <= cfg_wdata_i[POW_W-1:0];
          CFG_TARGET_RAW:    traw_q  <= cfg_wdata_i[TEMP_W-1:0];
          CFG_TARGET_BIAS:   tbias_q <= cfg_wdata_i[BIAS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      heater_q <= heater_power_i;
      dt_q     <= time_step_i;
      scale_q  <= scale_cl;
      lo_q     <= lo_cl;
      hi_q     <= hi_cl;
    end
    if (mul_done) begin
      unique case (state_q)
        ST_AMB:  amb_q     <= mp[MUL_B_W-SCALE_W+Q16_SHIFT +: TEMP_W];
        ST_SOL:  solar_q   <= mp[MUL_B_W-SCALE_W+Q16_SHIFT +: POW_W];
        ST_LOSS: begin
          loss_q <= loss_v;
          net_q  <= net_v;
        end
        ST_TGT:  tgt_q     <= tgt_v;
        ST_LO:   lo_prod_q <= mp[MUL_B_W-FRAC_W +: CMP_W];
        ST_HI:   band_q    <= band_v;
        default: begin
        end
      endcase
    end
    if (out_load) begin
      o_temp_q <= temp_q;
      o_amb_q  <= amb_q;
      o_loss_q <= loss_q;
      o_net_q  <= net_q;
      o_band_q <= band_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign node_temp_o    = o_temp_q;
  assign ambient_temp_o = o_amb_q;
  assign loss_power_o   = o_loss_q;
  assign net_power_o    = o_net_q;
  assign band_class_o   = o_band_q;

endmodule

/* rtl/ltns_checker.sv */
// Port-level checker for the thermal node stepper, bound to the top level.
module ltns_port_props (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ltns_pkg::TEMP_W-1:0]         node_temp_o,
  input logic [ltns_pkg::TEMP_W-1:0]         ambient_temp_o,
  input logic signed [ltns_pkg::OUT_P_W-1:0] loss_power_o,
  input logic signed [ltns_pkg::OUT_P_W-1:0] net_power_o,
  input logic [1:0]                          band_class_o
);

  // one beat at a time: busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // the block only frees up by handing over a result
  a_free_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("input freed without a result");

  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(node_temp_o) && $stable(ambient_temp_o)
      && $stable(loss_power_o) && $stable(net_power_o) && $stable(band_class_o))
    else $error("result changed while stalled");

endmodule

bind lumped_thermal_node_stepper ltns_port_props u_ltns_port_props (.*);
